>>> src/aes_pkg.sv
// shared constants, types and functions of the aes-128 stream cipher
package aes_pkg;

	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned NUM_ROUNDS = 10;

	localparam logic [1:0] CFG_KEY_HIGH  = 2'd0;
	localparam logic [1:0] CFG_KEY_LOW   = 2'd1;
	localparam logic [1:0] CFG_DIRECTION = 2'd2;

	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] GF_POLY    = 8'h1b;

	typedef logic [127:0] block_t;

	// command to the cipher core
	typedef struct packed {
		logic   start;
		logic   decrypt;
		block_t key;
		block_t data;
	} aes_cmd_t;

	typedef struct packed {
		logic   done;
		block_t data;
	} aes_rsp_t;

	localparam logic [7:0] FWD_SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
	endfunction

	// byte i of a block, byte zero in the top bits
	function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
		return b[127 - 8 * i -: 8];
	endfunction

endpackage

>>> src/aes_stream_if.sv
// valid/ready channel carrying one payload
interface aes_stream_if #(parameter int unsigned W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> src/aes128_stream_cipher_with_padding.sv
// top level: byte stream gathering, padding, aes-128 ecb and result streaming
// the 16th byte (or message end when encrypting) starts the core; for decryption
//   the core first walks the key schedule forward to the last round key
// input: one byte per cycle while gathering; it then stalls for the cipher and
//   for up to 16 result items (32 if encryption ends on a full block)
// reset: arst_n zeroes byte count, sequencer, keys and flags; not buf_q, res_q
module aes128_stream_cipher_with_padding
	import aes_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	aes_stream_if.sink   in_ch,
	aes_stream_if.sink   cfg,
	aes_stream_if.source out_ch
);

	// sequencer states
	localparam logic [1:0] ST_GATHER = 2'd0;
	localparam logic [1:0] ST_CIPHER = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;

	logic [1:0]   state_q;
	logic [63:0]  key_high_q, key_low_q;
	logic         direction_q;
	logic [3:0]   byte_count_q;
	block_t       buf_q;       // block buffer, byte zero on top
	logic         dec_q;       // direction sampled on block close
	logic         end_q;       // block carried the message end
	logic         extra_q;     // encryption: a pad-only block still follows
	logic         start_q;
	block_t       res_q;       // cipher result being emitted
	logic [3:0]   emit_idx_q;
	logic [3:0]   emit_last_q; // index of the last byte to emit
	logic         emit_mark_q; // out_last on the last emitted byte
	logic         err_q;       // single error item pending
	aes_cmd_t     cmd;
	aes_rsp_t     rsp;

	// payload layout: in {data_byte, message_end}, cfg {index, value}
	logic [7:0]   data_byte;
	logic         message_end;
	logic [1:0]   cfg_index;
	logic [63:0]  cfg_value;
	assign data_byte   = in_ch.payload[8:1];
	assign message_end = in_ch.payload[0];
	assign cfg_index   = cfg.payload[65:64];
	assign cfg_value   = cfg.payload[63:0];

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = (state_q == ST_GATHER);

	logic in_fire, out_fire;
	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;

	assign cmd.start   = start_q;
	assign cmd.decrypt = dec_q;
	assign cmd.key     = {key_high_q, key_low_q};
	assign cmd.data    = buf_q;

	aes_core u_core (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	// output payload {out_byte, out_last, error}
	logic [7:0] cur_byte;
	assign cur_byte = res_q[127 - 8 * emit_idx_q -: 8];
	assign out_ch.valid   = (state_q == ST_EMIT);
	assign out_ch.payload = err_q ? {8'h00, 1'b1, 1'b1}
		: {cur_byte, emit_mark_q && (emit_idx_q == emit_last_q), 1'b0};

	// short final block with the incoming byte, zero fill and pad count
	block_t padded;
	always_comb begin
		padded = buf_q;
		for (int i = 0; i < 16; i++)
			if (4'(i) > byte_count_q) padded[127 - 8 * i -: 8] = 8'h00;
		padded[7:0] = 8'(15 - byte_count_q);
		padded[127 - 8 * byte_count_q -: 8] = data_byte;
	end

	logic [7:0] pad_val;
	assign pad_val = rsp.data[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_GATHER;
			key_high_q   <= '0;
			key_low_q    <= '0;
			direction_q  <= 1'b0;
			byte_count_q <= '0;
			start_q      <= 1'b0;
			extra_q      <= 1'b0;
			err_q        <= 1'b0;
			end_q        <= 1'b0;
			dec_q        <= 1'b0;
			emit_idx_q   <= '0;
			emit_last_q  <= '0;
			emit_mark_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg_index)
					CFG_KEY_HIGH:  key_high_q  <= cfg_value;
					CFG_KEY_LOW:   key_low_q   <= cfg_value;
					CFG_DIRECTION: direction_q <= cfg_value[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_GATHER: begin
					if (in_fire) begin
						if (!direction_q && message_end && byte_count_q != 4'd15) begin
							buf_q <= padded;
						end else begin
							buf_q[127 - 8 * byte_count_q -: 8] <= data_byte;
						end
						if (byte_count_q != 4'd15 && !message_end) begin
							byte_count_q <= byte_count_q + 4'd1;
						end else begin
							byte_count_q <= '0;
							dec_q <= direction_q;
							end_q <= message_end;
							// misaligned ciphertext: one error item
							err_q <= direction_q && byte_count_q != 4'd15;
							if (direction_q && byte_count_q != 4'd15) begin
								state_q <= ST_EMIT;
							end else begin
								start_q <= 1'b1;
								state_q <= ST_CIPHER;
								extra_q <= !direction_q && message_end
									&& byte_count_q == 4'd15;
							end
						end
					end
				end
				ST_CIPHER: begin
					start_q <= 1'b0;
					if (rsp.done) begin
						res_q      <= rsp.data;
						emit_idx_q <= '0;
						emit_mark_q <= end_q && !extra_q;
						if (dec_q && end_q) begin
							err_q       <= pad_val == 8'd0 || pad_val > 8'd16;
							emit_last_q <= 4'(15 - pad_val);
							// whole block is padding: nothing to emit
							state_q     <= (pad_val == 8'd16) ? ST_GATHER : ST_EMIT;
						end else begin
							emit_last_q <= 4'd15;
							state_q     <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_fire) begin
						if (err_q) begin
							err_q   <= 1'b0;
							state_q <= ST_GATHER;
						end else if (emit_idx_q == emit_last_q) begin
							if (extra_q) begin
								extra_q <= 1'b0;
								buf_q   <= {120'd0, 8'd16};
								start_q <= 1'b1;
								state_q <= ST_CIPHER;
							end else begin
								state_q <= ST_GATHER;
							end
						end else begin
							emit_idx_q <= emit_idx_q + 4'd1;
						end
					end
				end
				default: state_q <= ST_GATHER;
			endcase
		end
	end

	// input is never taken while a block is in flight
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_GATHER) |-> !in_ch.ready)
		else $error("input accepted while busy");

	// core completes only while waiting for it
	a_done_in_cipher: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_CIPHER))
		else $error("core result outside cipher state");

	// an error item always closes the message
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.payload[0]) |-> out_ch.payload[1])
		else $error("error item without last mark");

endmodule

>>> src/aes_core.sv
// iterative aes-128 core: one round per cycle with on-the-fly key schedule
module aes_core
	import aes_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  aes_cmd_t cmd,
	output aes_rsp_t rsp
);

	logic         busy_q;
	logic         dec_q;
	logic [3:0]   round_q;
	block_t       state_q;
	block_t       rkey_q;
	logic [7:0]   rcon_q;
	logic         prep_q;
	logic         done_q;

	// forward key schedule step
	function automatic block_t key_next(input block_t k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {FWD_SBOX[w3[23:16]] ^ rc, FWD_SBOX[w3[15:8]], FWD_SBOX[w3[7:0]],
			FWD_SBOX[w3[31:24]]};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// inverse key schedule step
	function automatic block_t key_prev(input block_t k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		w3 = w3 ^ w2; w2 = w2 ^ w1; w1 = w1 ^ w0;
		t = {FWD_SBOX[w3[23:16]] ^ rc, FWD_SBOX[w3[15:8]], FWD_SBOX[w3[7:0]],
			FWD_SBOX[w3[31:24]]};
		w0 = w0 ^ t;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [7:0] rc_prev(input logic [7:0] rc);
		return rc[0] ? ({1'b0, rc[7:1]} ^ 8'h8d) : {1'b0, rc[7:1]};
	endfunction

	function automatic block_t enc_round(input block_t s, input logic last);
		block_t t;
		logic [7:0] a0, a1, a2, a3, al;
		for (int i = 0; i < 16; i++)
			t[127 - 8 * i -: 8] = FWD_SBOX[get_byte(s, (i % 4) + 4 * (((i / 4) + (i % 4)) % 4))];
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[127 - 32 * c -: 8]; a1 = t[119 - 32 * c -: 8];
				a2 = t[111 - 32 * c -: 8]; a3 = t[103 - 32 * c -: 8];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[127 - 32 * c -: 8] = a0 ^ al ^ xt(a0 ^ a1);
				t[119 - 32 * c -: 8] = a1 ^ al ^ xt(a1 ^ a2);
				t[111 - 32 * c -: 8] = a2 ^ al ^ xt(a2 ^ a3);
				t[103 - 32 * c -: 8] = a3 ^ al ^ xt(a3 ^ a0);
			end
		end
		return t;
	endfunction

	function automatic block_t inv_mix(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, u, v;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8]; a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8]; a3 = s[103 - 32 * c -: 8];
			// inverse mix as a pre-step then the forward mix
			u = xt(xt(a0 ^ a2));
			v = xt(xt(a1 ^ a3));
			a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
			t[127 - 32 * c -: 8] = a0 ^ (a0 ^ a1 ^ a2 ^ a3) ^ xt(a0 ^ a1);
			t[119 - 32 * c -: 8] = a1 ^ (a0 ^ a1 ^ a2 ^ a3) ^ xt(a1 ^ a2);
			t[111 - 32 * c -: 8] = a2 ^ (a0 ^ a1 ^ a2 ^ a3) ^ xt(a2 ^ a3);
			t[103 - 32 * c -: 8] = a3 ^ (a0 ^ a1 ^ a2 ^ a3) ^ xt(a3 ^ a0);
		end
		return t;
	endfunction

	function automatic block_t inv_shsub(input block_t s);
		block_t t;
		for (int i = 0; i < 16; i++)
			t[127 - 8 * ((i % 4) + 4 * (((i / 4) + (i % 4)) % 4)) -: 8] = INV_SBOX[get_byte(s, i)];
		return t;
	endfunction

	block_t     next_key;
	block_t     round_out;

	always_comb begin
		next_key  = dec_q ? key_prev(rkey_q, rcon_q) : key_next(rkey_q, rcon_q);
		if (dec_q) begin
			// state holds (after inverse mix) data before inverse shift/sub
			round_out = inv_shsub(state_q) ^ next_key;
			if (round_q != 4'(NUM_ROUNDS))
				round_out = inv_mix(round_out);
		end else begin
			round_out = enc_round(state_q, round_q == 4'(NUM_ROUNDS)) ^ next_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			prep_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && round_q == 4'(NUM_ROUNDS);
			if (cmd.start && !busy_q && !prep_q) begin
				dec_q   <= cmd.decrypt;
				state_q <= cmd.decrypt ? cmd.data : (cmd.data ^ cmd.key);
				rkey_q  <= cmd.key;
				rcon_q  <= RCON_FIRST;
				round_q <= cmd.decrypt ? 4'd0 : 4'd1;
				prep_q  <= cmd.decrypt;
				busy_q  <= !cmd.decrypt;
			end else if (prep_q) begin
				// walk the key schedule forward to the last round key
				rkey_q <= key_next(rkey_q, rcon_q);
				if (round_q == 4'(NUM_ROUNDS - 1)) begin
					prep_q  <= 1'b0;
					busy_q  <= 1'b1;
					state_q <= state_q ^ key_next(rkey_q, rcon_q);
					round_q <= 4'd1;
					// round constant of the last round
					rcon_q  <= 8'h36;
				end else begin
					rcon_q  <= xt(rcon_q);
					round_q <= round_q + 4'd1;
				end
			end else if (busy_q) begin
				if (dec_q) begin
					rkey_q <= next_key;
					rcon_q <= rc_prev(rcon_q);
				end else begin
					rkey_q <= next_key;
					rcon_q <= xt(rcon_q);
				end
				state_q <= round_out;
				round_q <= round_q + 4'd1;
				if (round_q == 4'(NUM_ROUNDS))
					busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.data = state_q;

endmodule
